@@ rtl/bsle_pkg.sv @@
// Shared types and constants for the bounded sequence list engine.
package bsle_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 4;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 6;
    localparam int ST_W         = 2;
    localparam int LEN_W        = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 4'd0,
        OP_INS_LAST  = 4'd1,
        OP_RM_FIRST  = 4'd2,
        OP_RM_LAST   = 4'd3,
        OP_RM_VALUE  = 4'd4,
        OP_RM_INDEX  = 4'd5,
        OP_GET_INDEX = 4'd6,
        OP_EXISTS    = 4'd7,
        OP_COUNT     = 4'd8,
        OP_SORT      = 4'd9,
        OP_CLEAR     = 4'd10
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHR,
        S_SHR_WR,
        S_GET,
        S_GET_DATA,
        S_DROP,
        S_DROP_WR,
        S_SCAN,
        S_SCAN_CHK,
        S_SORT_I,
        S_SORT_CUR,
        S_SORT_J,
        S_SORT_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

endpackage

@@ rtl/bsle_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface bsle_req_if;
    import bsle_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    logic                    ascending;

    modport source (output valid, op, item_value, position, ascending, input ready);
    modport sink   (input valid, op, item_value, position, ascending, output ready);
endinterface

interface bsle_rsp_if;
    import bsle_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;

    modport source (output valid, status, read_value, length, input ready);
    modport sink   (input valid, status, read_value, length, output ready);
endinterface

@@ rtl/bsle_mem.sv @@
// Entry store: one write port, one read port with registered read data.
module bsle_mem
    import bsle_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  mem_cmd_t         cmd,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/bsle_ctrl.sv @@
// Operation sequencer: walks the entry store and builds each response.
module bsle_ctrl
    import bsle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    bsle_req_if.sink         req,
    bsle_rsp_if.source       rsp,
    output mem_cmd_t         mcmd,
    output logic [AW-1:0]    waddr,
    output logic [VAL_W-1:0] wdata,
    output logic [AW-1:0]    raddr,
    input  logic [VAL_W-1:0] rdata
);

    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             up_reg, up_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    jdx_reg, jdx_next;
    logic [VAL_W-1:0] cur_reg, cur_next;
    logic [CW-1:0]    count_reg, count_next;
    status_t          st_reg, st_next;
    logic [VAL_W-1:0] rd_reg, rd_next;
    logic             ovld_reg, ovld_next;
    logic [ST_W-1:0]  ost_reg, ost_next;
    logic [VAL_W-1:0] oval_reg, oval_next;
    logic [LEN_W-1:0] olen_reg, olen_next;

    logic          full, empty, pos_ok, out_free, move, accept;
    logic [CW-1:0] idx_inc, cnt_len;
    logic [LW-1:0] len_x;

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_ok   = (XW'(req.position) < XW'(count_reg));
    assign out_free = !ovld_reg || rsp.ready;
    assign idx_inc  = idx_reg + CW'(1);
    assign move     = up_reg ? ($signed(rdata) > $signed(cur_reg))
                             : ($signed(rdata) < $signed(cur_reg));
    assign accept   = req.valid && req.ready;
    assign cnt_len  = count_next;
    assign len_x    = LW'(cnt_len);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovld_reg;
    assign rsp.status     = ost_reg;
    assign rsp.read_value = oval_reg;
    assign rsp.length     = olen_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (op_t'(req.op))
                        OP_INS_FIRST: state_next = full ? S_DONE : S_SHR;
                        OP_RM_FIRST, OP_RM_LAST:
                            state_next = empty ? S_DONE : S_GET;
                        OP_RM_INDEX, OP_GET_INDEX:
                            state_next = pos_ok ? S_GET : S_DONE;
                        OP_RM_VALUE, OP_EXISTS: state_next = S_SCAN;
                        OP_SORT:      state_next = S_SORT_I;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_SHR:      state_next = (idx_reg == '0) ? S_DONE : S_SHR_WR;
            S_SHR_WR:   state_next = S_SHR;
            S_GET:      state_next = S_GET_DATA;
            S_GET_DATA:
            begin
                if (op_reg == OP_GET_INDEX || op_reg == OP_RM_LAST)
                    state_next = S_DONE;
                else
                    state_next = S_DROP;
            end
            S_DROP:     state_next = (idx_inc >= count_reg) ? S_DONE : S_DROP_WR;
            S_DROP_WR:  state_next = S_DROP;
            S_SCAN:     state_next = (idx_reg >= count_reg) ? S_DONE : S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (rdata == val_reg)
                    state_next = (op_reg == OP_EXISTS) ? S_DONE : S_DROP;
                else
                    state_next = S_SCAN;
            end
            S_SORT_I:   state_next = (idx_reg >= count_reg) ? S_DONE : S_SORT_CUR;
            S_SORT_CUR: state_next = S_SORT_J;
            S_SORT_J:   state_next = (jdx_reg == '0) ? S_SORT_I : S_SORT_CMP;
            S_SORT_CMP: state_next = move ? S_SORT_J : S_SORT_I;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next    = op_reg;
        val_next   = val_reg;
        up_next    = up_reg;
        idx_next   = idx_reg;
        jdx_next   = jdx_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        ovld_next  = ovld_reg && !rsp.ready;
        ost_next   = ost_reg;
        oval_next  = oval_reg;
        olen_next  = olen_reg;
        mcmd       = '0;
        waddr      = idx_reg[AW-1:0];
        wdata      = rdata;
        raddr      = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(req.op);
                    val_next = req.item_value;
                    up_next  = req.ascending;
                    st_next  = ST_OK;
                    rd_next  = '0;
                    case (op_t'(req.op))
                        OP_INS_FIRST:
                        begin
                            if (full) st_next = ST_FULL;
                            idx_next = count_reg;
                        end
                        OP_INS_LAST:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                mcmd.we    = 1'b1;
                                waddr      = count_reg[AW-1:0];
                                wdata      = req.item_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_RM_FIRST:
                        begin
                            if (empty) st_next = ST_MISS;
                            idx_next = '0;
                        end
                        OP_RM_LAST:
                        begin
                            if (empty) st_next = ST_MISS;
                            idx_next = count_reg - CW'(1);
                        end
                        OP_RM_INDEX, OP_GET_INDEX:
                        begin
                            if (!pos_ok) st_next = ST_MISS;
                            idx_next = CW'(XW'(req.position));
                        end
                        OP_RM_VALUE, OP_EXISTS: idx_next = '0;
                        OP_SORT:      idx_next = CW'(1);
                        OP_COUNT:     st_next = ST_OK;
                        OP_CLEAR:     count_next = '0;
                        default:      st_next = ST_MISS;
                    endcase
                end
            end
            S_SHR:
            begin
                if (idx_reg == '0)
                begin
                    mcmd.we    = 1'b1;
                    waddr      = '0;
                    wdata      = val_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    mcmd.re = 1'b1;
                    raddr   = AW'(idx_reg - CW'(1));
                end
            end
            S_SHR_WR:
            begin
                mcmd.we  = 1'b1;
                idx_next = idx_reg - CW'(1);
            end
            S_GET:      mcmd.re = 1'b1;
            S_GET_DATA:
            begin
                rd_next = rdata;
                if (op_reg == OP_RM_LAST) count_next = count_reg - CW'(1);
            end
            S_DROP:
            begin
                if (idx_inc >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    mcmd.re = 1'b1;
                    raddr   = idx_inc[AW-1:0];
                end
            end
            S_DROP_WR:
            begin
                mcmd.we  = 1'b1;
                idx_next = idx_inc;
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg)
                    st_next = ST_MISS;
                else
                    mcmd.re = 1'b1;
            end
            S_SCAN_CHK:
            begin
                if (rdata == val_reg)
                begin
                    if (op_reg != OP_EXISTS) rd_next = rdata;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SORT_I:
            begin
                if (idx_reg < count_reg) mcmd.re = 1'b1;
            end
            S_SORT_CUR:
            begin
                cur_next = rdata;
                jdx_next = idx_reg;
            end
            S_SORT_J:
            begin
                if (jdx_reg == '0)
                begin
                    mcmd.we  = 1'b1;
                    waddr    = '0;
                    wdata    = cur_reg;
                    idx_next = idx_inc;
                end
                else
                begin
                    mcmd.re = 1'b1;
                    raddr   = AW'(jdx_reg - CW'(1));
                end
            end
            S_SORT_CMP:
            begin
                mcmd.we = 1'b1;
                waddr   = jdx_reg[AW-1:0];
                if (move)
                begin
                    wdata    = rdata;
                    jdx_next = jdx_reg - CW'(1);
                end
                else
                begin
                    wdata    = cur_reg;
                    idx_next = idx_inc;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovld_next = 1'b1;
                    ost_next  = st_reg;
                    oval_next = rd_reg;
                    olen_next = len_x[LEN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        up_reg   <= up_next;
        idx_reg  <= idx_next;
        jdx_reg  <= jdx_next;
        cur_reg  <= cur_next;
        st_reg   <= st_next;
        rd_reg   <= rd_next;
        ost_reg  <= ost_next;
        oval_reg <= oval_next;
        olen_reg <= olen_next;
    end

endmodule

@@ rtl/bounded_sequence_list_engine_core.sv @@
// Top level of the bounded sequence list engine.
//
//  channel | dir | payload                              | transfer
//  req     | in  | op, item_value, position, ascending  | valid && ready
//  rsp     | out | status, read_value, length           | valid && ready
//
// One request at a time; every request yields one response.
// Insert last, count and clear go from idle straight to the response; walks
// over the entry store move or search one entry at a time.
// Sort is an insertion sort over the stored entries.
// Reset empties the list at once; rsp holds its transfer until taken.
module bounded_sequence_list_engine_core
    import bsle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    bsle_req_if.sink   req,
    bsle_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    mem_cmd_t         mcmd;
    logic [AW-1:0]    waddr, raddr;
    logic [VAL_W-1:0] wdata, rdata;

    bsle_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .mcmd  (mcmd),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    bsle_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .clk   (clk),
        .cmd   (mcmd),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule
